[rtl/csvf_pkg.sv]
`timescale 1ns / 1ps
package csvf_pkg;

    // operand and coefficient sizes of the shared multiplier
    localparam int OPD_W   = 26;
    localparam int COEF_W  = 20;
    localparam int DIGIT_W = 4;
    localparam int N_DIGITS = (COEF_W + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W   = $clog2(N_DIGITS);
    localparam int PROD_W  = OPD_W + COEF_W;
    localparam int FRAC_W  = 16;
    localparam int RES_W   = PROD_W - FRAC_W;
    localparam int STATE_W = 24;
    localparam int SMP_W   = 16;

    localparam logic [16:0] COEF_ONE = 17'd65536;

    typedef enum logic [1:0] {
        CFG_G = 2'd0,
        CFG_K = 2'd1,
        CFG_D = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } t_state;

    // one product per step, in the order the recurrence needs them
    typedef enum logic [2:0] {
        STEP_K_A1   = 3'd0,
        STEP_D_ACC1 = 3'd1,
        STEP_G_HP   = 3'd2,
        STEP_G_BP   = 3'd3,
        STEP_K_LP   = 3'd4,
        STEP_D_ACC2 = 3'd5,
        STEP_G_HP2  = 3'd6,
        STEP_G_BP2  = 3'd7
    } t_step;

    typedef struct packed {
        logic                     start;
        logic signed [OPD_W-1:0]  opd;
        logic [COEF_W-1:0]        coef;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [RES_W-1:0]  prod;
    } t_mul_rsp;

    function automatic logic [16:0] clamp_one(input logic [16:0] v);
        return (v > COEF_ONE) ? COEF_ONE : v;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            return 24'sh800000;
        end
        return v[STATE_W-1:0];
    endfunction

    // Q4.20 -> Q1.15, round half up, saturate
    function automatic logic signed [SMP_W-1:0] to_q15(input logic signed [STATE_W-1:0] y);
        logic signed [STATE_W:0] s;
        s = 25'(y) + 25'sd16;
        s = s >>> 5;
        if (s > 25'sd32767) begin
            return 16'sh7FFF;
        end else if (s < -25'sd32768) begin
            return 16'sh8000;
        end
        return s[SMP_W-1:0];
    endfunction

endpackage

[rtl/csvf_mul.sv]
`timescale 1ns / 1ps
module csvf_mul
    import csvf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [COEF_W-1:0]        r_coef;
    logic signed [OPD_W-1:0]  r_a;
    logic signed [PROD_W-1:0] r_p;

    logic signed [DIGIT_W:0]         digit;
    logic signed [OPD_W+DIGIT_W:0]   part;
    logic signed [PROD_W-1:0]        rnd;

    // coefficient digits enter msb first, horner style
    assign digit = $signed({1'b0, r_coef[COEF_W-1 -: DIGIT_W]});
    assign part  = r_a * digit;
    assign rnd   = r_p + PROD_W'(32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(N_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.opd;
            r_coef <= i_req.coef;
            r_p    <= '0;
        end else if (r_busy) begin
            r_p    <= (r_p <<< DIGIT_W) + PROD_W'(part);
            r_coef <= r_coef << DIGIT_W;
        end
    end

    // floor of (p + half) / 2^16
    assign o_rsp.done = r_done;
    assign o_rsp.prod = rnd[PROD_W-1:FRAC_W];

endmodule

[rtl/cascaded_svf_lowpass_top.sv]
`timescale 1ns / 1ps
// Two cascaded state-variable low-pass stages on Q1.15 samples, state kept in Q4.20.
// Software writes g (index 0, Q4.16), k (index 1, Q1.16) and d = 1/(1+g) (index 2,
// Q1.16) while no word is in flight; k and d come from the low 17 bits of the word,
// and values above 1.0 there are taken as 1.0. All eight coefficient products of a
// sample go through one shared multiplier that takes the coefficient 4 bits per
// cycle. A new sample is accepted only once the last product of the previous one is
// written back and its result moved into the output register, where a finished word
// waits while the next sample is accepted.
module cascaded_svf_lowpass_top
    import csvf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [SMP_W-1:0] i_sample_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SMP_W-1:0] o_sample_out,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [COEF_W-1:0]       i_cfg_data
);

    t_state r_state, n_state;
    t_step  r_step;

    logic [COEF_W-1:0] r_g;
    logic [16:0]       r_k;
    logic [16:0]       r_d;

    logic signed [STATE_W-1:0] r_a1, r_a3, r_a4;
    logic signed [SMP_W-1:0]   r_x;
    logic signed [OPD_W-1:0]   r_acc;
    logic signed [STATE_W-1:0] r_hp, r_bp, r_lp, r_bp2, r_y;
    logic                      r_out_valid;
    logic signed [SMP_W-1:0]   r_out;

    logic     mul_start, wb_en, out_load, in_ready;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic signed [31:0] m32, x32;

    csvf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= COEF_W'(65536);
            r_k <= 17'd32768;
            r_d <= 17'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_G:   r_g <= i_cfg_data;
                CFG_K:   r_k <= clamp_one(i_cfg_data[16:0]);
                CFG_D:   r_d <= clamp_one(i_cfg_data[16:0]);
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_ISSUE;
            ST_ISSUE:  n_state = ST_WAIT;
            ST_WAIT: begin
                if (mul_rsp.done) begin
                    n_state = (r_step == STEP_G_BP2) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_FINISH: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        wb_en     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready  = 1'b1;
            ST_ISSUE:  mul_start = 1'b1;
            ST_WAIT:   wb_en     = mul_rsp.done;
            ST_FINISH: out_load  = !r_out_valid || i_out_ready;
            default:   ;
        endcase
    end

    // operand and coefficient for the current product
    always_comb begin
        mul_req.start = mul_start;
        mul_req.opd   = OPD_W'(r_a1);
        mul_req.coef  = COEF_W'(r_k);
        unique case (r_step)
            STEP_K_A1: begin
                mul_req.opd  = OPD_W'(r_a1);
                mul_req.coef = COEF_W'(r_k);
            end
            STEP_D_ACC1, STEP_D_ACC2: begin
                mul_req.opd  = r_acc;
                mul_req.coef = COEF_W'(r_d);
            end
            STEP_G_HP, STEP_G_HP2: begin
                mul_req.opd  = OPD_W'(r_hp);
                mul_req.coef = r_g;
            end
            STEP_G_BP: begin
                mul_req.opd  = OPD_W'(r_bp);
                mul_req.coef = r_g;
            end
            STEP_K_LP: begin
                mul_req.opd  = OPD_W'(r_lp);
                mul_req.coef = COEF_W'(r_k);
            end
            STEP_G_BP2: begin
                mul_req.opd  = OPD_W'(r_bp2);
                mul_req.coef = r_g;
            end
            default: ;
        endcase
    end

    assign m32 = 32'(mul_rsp.prod);
    assign x32 = 32'(r_x) <<< 5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_K_A1;
            r_a1        <= '0;
            r_a3        <= '0;
            r_a4        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_ready && i_in_valid) begin
                r_step <= STEP_K_A1;
            end else if (wb_en && r_step != STEP_G_BP2) begin
                r_step <= t_step'(3'(r_step + 3'd1));
            end
            // states move only once the whole sample is done
            if (wb_en && r_step == STEP_G_BP2) begin
                r_a1 <= r_bp;
                r_a3 <= r_bp2;
                r_a4 <= r_hp;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_x <= i_sample_in;
        end
        if (wb_en) begin
            unique case (r_step)
                STEP_K_A1:   r_acc <= OPD_W'(x32 - m32 - 32'(r_a3));
                STEP_D_ACC1: r_hp  <= sat24(m32);
                STEP_G_HP:   r_bp  <= sat24(m32 + 32'(r_a1));
                STEP_G_BP:   r_lp  <= sat24(m32 + 32'(r_a3));
                STEP_K_LP:   r_acc <= OPD_W'(32'(r_lp) - m32 - 32'(r_a4));
                STEP_D_ACC2: r_hp  <= sat24(m32);
                STEP_G_HP2:  r_bp2 <= sat24(m32 + 32'(r_lp));
                STEP_G_BP2:  r_y   <= sat24(m32 + 32'(r_a4));
                default:     ;
            endcase
        end
        if (out_load) begin
            r_out <= to_q15(r_y);
        end
    end

    assign o_in_ready   = in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

[rtl/csvf_chk.sv]
`timescale 1ns / 1ps
module csvf_chk
    import csvf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [SMP_W-1:0] o_sample_out
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready right after a word was accepted");

    // the multiply chain cannot finish this early
    a_no_early_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##8 !o_in_ready)
        else $error("block ready again too soon after an accepted word");

    // a new result only appears at the end of a computation
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("output word appeared with no computation running");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output word changed or dropped");

endmodule

bind cascaded_svf_lowpass_top csvf_chk u_csvf_chk (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import csvf_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int N_RANDOM = 1650;
    localparam int IDLE_PCT = 13;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam longint ONE_Q16 = 65536;

    typedef enum {RUN_DC, RUN_NOISE, RUN_WALK, RUN_SQUARE, RUN_QUIET} t_run;

    class lowpass_checker;
        logic [COEF_W-1:0] gain;
        logic [16:0] damp;
        logic [16:0] inv_gain;
        longint band1;
        longint band2;
        longint high2;
        logic signed [SMP_W-1:0] pending_out[$];
        int n_in;
        int n_out;
        int n_err;

        function new();
            gain = 20'd65536;
            damp = 17'd32768;
            inv_gain = 17'd32768;
            band1 = 0;
            band2 = 0;
            high2 = 0;
            n_in = 0;
            n_out = 0;
            n_err = 0;
        endfunction

        function void apply_write(logic [1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_G: gain = data;
                CFG_K: damp = (data[16:0] > ONE_Q16) ? 17'(ONE_Q16) : data[16:0];
                CFG_D: inv_gain = (data[16:0] > ONE_Q16) ? 17'(ONE_Q16) : data[16:0];
                default: ;
            endcase
        endfunction

        // product with a Q.16 coefficient, rounded half up back to Q4.20
        function longint coef_mul(longint a, longint c);
            return (a * c + 32768) >>> 16;
        endfunction

        function longint clip24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void note_sample(logic signed [SMP_W-1:0] s);
            longint x, acc, hp, bp, lp, hp2, bp2, y, q;
            x = longint'(s) * 32;
            acc = x - coef_mul(band1, damp) - band2;
            hp = clip24(coef_mul(acc, inv_gain));
            bp = clip24(coef_mul(hp, gain) + band1);
            lp = clip24(coef_mul(bp, gain) + band2);
            // second stage uses lp in place of its own band state
            acc = lp - coef_mul(lp, damp) - high2;
            hp2 = clip24(coef_mul(acc, inv_gain));
            bp2 = clip24(coef_mul(hp2, gain) + lp);
            y = clip24(coef_mul(bp2, gain) + high2);
            band1 = bp;
            band2 = bp2;
            high2 = hp2;
            q = (y + 16) >>> 5;
            if (q > 32767) q = 32767;
            else if (q < -32768) q = -32768;
            pending_out.push_back(q[SMP_W-1:0]);
            n_in++;
        endfunction

        task report_mismatch(string what);
            n_err++;
            $display("mismatch: %s", what);
        endtask

        task check_sample(logic signed [SMP_W-1:0] got);
            logic signed [SMP_W-1:0] want;
            n_out++;
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("output word %0d (%0d) with nothing pending",
                                          n_out, got));
                return;
            end
            want = pending_out.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("word %0d: sample_out %0d, expected %0d",
                                          n_out, got, want));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [SMP_W-1:0] i_sample_in = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [SMP_W-1:0] o_sample_out;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_idx = '0;
    logic [COEF_W-1:0]       i_cfg_data = '0;

    lowpass_checker sb = new();
    bit no_idle = 1'b0;
    int cycles = 0;
    int n_settings = 0;

    cascaded_svf_lowpass_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_sample(o_sample_out);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[cascaded_svf_lowpass_top] ERROR");
            $finish;
        end
    end

    // valid is left high after acceptance; the next call or settle decides
    task automatic send_sample(logic signed [SMP_W-1:0] v);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_in <= v;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(v);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.apply_write(idx, data);
    endtask

    task automatic program_filter(logic [COEF_W-1:0] g, logic [COEF_W-1:0] k,
                                  logic [COEF_W-1:0] d, bit spare);
        write_reg(CFG_G, g);
        write_reg(CFG_K, k);
        write_reg(CFG_D, d);
        // a write to the unused index must leave all coefficients alone
        if (spare) write_reg(CFG_SPARE, COEF_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_out.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        longint g, k, d;
        int cur, run_left, sent, phase, n_phase;
        t_run run;

        run = RUN_DC;
        run_left = 0;
        cur = 0;
        sent = 0;
        phase = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: full scale steps and tiny values
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);

        // maximum gain, damping and inverse above one get clamped
        settle();
        program_filter(20'hFFFFF, 20'hFFFFF, 20'd65537, 1'b1);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd0);

        // zero gain freezes the stages, zero inverse kills the high-pass terms
        settle();
        program_filter(20'd0, 20'd65536, 20'd0, 1'b0);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd1);
        send_sample(-16'sd1);

        settle();
        program_filter(20'd65536, 20'd0, 20'd65536, 1'b0);
        send_sample(16'sd12345);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);

        while (sent < N_RANDOM) begin
            settle();
            if ($urandom_range(3) == 0) begin
                g = $urandom_range(0, 20'hFFFFF);
                k = $urandom_range(0, 20'hFFFFF);
                d = $urandom_range(0, 20'hFFFFF);
            end else begin
                g = $urandom_range(0, 131072);
                k = $urandom_range(0, 65536);
                d = ((64'd1 << 32) + (ONE_Q16 + g) / 2) / (ONE_Q16 + g);
            end
            program_filter(COEF_W'(g), COEF_W'(k), COEF_W'(d), $urandom_range(3) == 0);
            no_idle = (phase == 3);
            n_phase = $urandom_range(80, 200);
            for (int j = 0; j < n_phase && sent < N_RANDOM; j++) begin
                if (run_left == 0) begin
                    run = t_run'($urandom_range(4));
                    run_left = $urandom_range(4, 40);
                    cur = $urandom_range(0, 65535) - 32768;
                end
                case (run)
                    RUN_DC: ;
                    RUN_NOISE: cur = $urandom_range(0, 65535) - 32768;
                    RUN_WALK: begin
                        cur = cur + $urandom_range(0, 4096) - 2048;
                        if (cur > 32767) cur = 32767;
                        else if (cur < -32768) cur = -32768;
                    end
                    RUN_SQUARE: if (run_left % 4 == 0) cur = -cur - 1;
                    RUN_QUIET: cur = $urandom_range(0, 64) - 32;
                    default: ;
                endcase
                run_left--;
                send_sample(16'(cur));
                sent++;
            end
            phase++;
        end
        no_idle = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d samples over %0d coefficient settings, %0d output words compared",
                 sb.n_in, n_settings, sb.n_out);
        $display("%0d mismatches in %0d cycles", sb.n_err, cycles);
        if (sb.n_err == 0) begin
            $display("[cascaded_svf_lowpass_top] OK");
        end else begin
            $display("[cascaded_svf_lowpass_top] ERROR");
        end
        $finish;
    end

endmodule
